// ===== design/ufmc_pkg.sv =====
// Shared types and constants for the union-find maze wall carver.
// No dependencies; the datapath, controller and top level refer to this package.

package ufmc_pkg;

    // Fixed field widths
    localparam int SIDE_W  = 6;
    localparam int COORD_W = 7;
    localparam int CELL_W  = 2 * SIDE_W + 1;

    // Command codes on the input channel
    localparam logic CMD_CLEAR = 1'b0;

    // Configuration register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Configuration reset values
    localparam logic [SIDE_W-1:0] COLS_RST = 6'd4;
    localparam logic [SIDE_W-1:0] ROWS_RST = 6'd4;

    // Channel payloads
    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
    } t_in_beat;

    typedef struct packed {
        logic carved;
        logic invalid_wall;
    } t_out_beat;

    typedef struct packed {
        logic              index;
        logic [SIDE_W-1:0] value;
    } t_cfg_beat;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_FIND_A,
        S_WB_A,
        S_ISSUE_B,
        S_FIND_B,
        S_WB_B,
        S_LINK,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic decode;
        logic clr_step;
        logic issue;
        logic find;
        logic wb;
        logic link;
        logic res_clear;
        logic res_invalid;
        logic out_load;
        logic sel_b;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_clear;
        logic wall_ok;
        logic found;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/ufmc_chan_if.sv =====
// Valid/ready channel interface used for the input, result and configuration ports.
// The payload type is supplied per instance; types come from ufmc_pkg.

interface ufmc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ufmc_ram.sv =====
// Generic single-port RAM with a registered read port.
// No dependencies.

module ufmc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ufmc_dp.sv =====
// Datapath of the maze wall carver: configuration, wall decode, parent table,
// root-search walker and result register. Uses ufmc_pkg and ufmc_ram.

module ufmc_dp #(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_SIDE  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  ufmc_pkg::t_cfg_beat i_cfg_data,
    input  ufmc_pkg::t_in_beat  i_in_data,
    input  ufmc_pkg::t_dp_cmd   i_cmd,
    output ufmc_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ufmc_pkg::t_out_beat o_out_data
);

    localparam int DEPTH  = MAX_CELLS + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int STEP_W = $clog2(MAX_CELLS + 2);
    localparam int SIDE_W = ufmc_pkg::SIDE_W;
    localparam int CELL_W = ufmc_pkg::CELL_W;

    logic [SIDE_W-1:0]   r_cols_cfg;
    logic [SIDE_W-1:0]   r_rows_cfg;
    ufmc_pkg::t_in_beat  r_in;
    logic [CELL_W-1:0]   r_cell_a;
    logic [CELL_W-1:0]   r_cell_b;
    logic                r_geom_ok;
    logic [IDX_W-1:0]    r_src;
    logic [IDX_W-1:0]    r_cur;
    logic [STEP_W-1:0]   r_steps;
    logic [IDX_W-1:0]    r_root_a;
    logic [IDX_W-1:0]    r_root_b;
    logic [IDX_W-1:0]    r_clr;
    logic                r_res_carved;
    logic                r_res_invalid;
    logic                r_out_valid;
    ufmc_pkg::t_out_beat r_out_data;

    logic [SIDE_W-1:0]   cols_eff;
    logic [SIDE_W-1:0]   rows_eff;
    logic [7:0]          rows2;
    logic [7:0]          cols2;
    logic [7:0]          wr8;
    logic [7:0]          wc8;
    logic                odd_row;
    logic                geom_ok;
    logic [6:0]          row_m1;
    logic [6:0]          col_m1;
    logic [2*SIDE_W-1:0] prod;
    logic [CELL_W-1:0]   cell_a;
    logic [CELL_W-1:0]   cell_b;
    logic [IDX_W-1:0]    entry_a;
    logic [IDX_W-1:0]    entry_b;
    logic [IDX_W-1:0]    src_sel;
    logic [IDX_W-1:0]    link;
    logic                stop_root;
    logic                beyond;
    logic                found;
    logic [IDX_W-1:0]    root;
    logic [IDX_W-1:0]    wb_root;
    logic                clr_last;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [IDX_W-1:0]    ram_wdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= ufmc_pkg::COLS_RST;
            r_rows_cfg <= ufmc_pkg::ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_data.index)
                ufmc_pkg::REG_COLS: r_cols_cfg <= i_cfg_data.value;
                ufmc_pkg::REG_ROWS: r_rows_cfg <= i_cfg_data.value;
                default: ;
            endcase
        end
    end

    // Clamp grid sides: zero acts as one, large values saturate
    always_comb begin
        if (r_cols_cfg == '0) begin
            cols_eff = SIDE_W'(1);
        end else if (32'(r_cols_cfg) > MAX_SIDE) begin
            cols_eff = SIDE_W'(MAX_SIDE);
        end else begin
            cols_eff = r_cols_cfg;
        end
        if (r_rows_cfg == '0) begin
            rows_eff = SIDE_W'(1);
        end else if (32'(r_rows_cfg) > MAX_SIDE) begin
            rows_eff = SIDE_W'(MAX_SIDE);
        end else begin
            rows_eff = r_rows_cfg;
        end
    end

    // Wall range check and cell numbering
    always_comb begin
        rows2   = {1'b0, rows_eff, 1'b0};
        cols2   = {1'b0, cols_eff, 1'b0};
        wr8     = {1'b0, r_in.wall_row};
        wc8     = {1'b0, r_in.wall_col};
        odd_row = r_in.wall_row[0];
        if (odd_row) begin
            geom_ok = (wr8 <= rows2 - 8'd1) && !wc8[0] && (wc8 >= 8'd2)
                      && (wc8 <= cols2 - 8'd2);
        end else begin
            geom_ok = (wr8 >= 8'd2) && (wr8 <= rows2 - 8'd2) && wc8[0]
                      && (wc8 <= cols2 - 8'd1);
        end
        row_m1 = r_in.wall_row - 7'd1;
        col_m1 = r_in.wall_col - 7'd1;
        prod   = row_m1[6:1] * cols_eff;
        cell_a = CELL_W'(prod) + CELL_W'(col_m1[6:1]);
        cell_b = odd_row ? cell_a + CELL_W'(1) : cell_a + CELL_W'(cols_eff);
    end

    // Root walker: one parent link per cycle
    assign entry_a   = IDX_W'(32'(r_cell_a) + 32'd1);
    assign entry_b   = IDX_W'(32'(r_cell_b) + 32'd1);
    assign src_sel   = i_cmd.sel_b ? entry_b : entry_a;
    assign stop_root = (link == '0) || (32'(r_steps) > MAX_CELLS);
    assign beyond    = 32'(link) > MAX_CELLS;
    assign found     = stop_root || beyond;
    assign root      = stop_root ? r_cur : r_src;
    assign wb_root   = i_cmd.sel_b ? r_root_b : r_root_a;
    assign clr_last  = 32'(r_clr) == MAX_CELLS;

    // Table port select
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_cur;
        ram_wdata = '0;
        if (i_cmd.clr_step) begin
            ram_addr = r_clr;
            ram_we   = 1'b1;
        end else if (i_cmd.issue) begin
            ram_addr = src_sel;
        end else if (i_cmd.find) begin
            ram_addr = found ? r_cur : link;
        end else if (i_cmd.wb) begin
            ram_addr  = r_src;
            ram_we    = wb_root != r_src;
            ram_wdata = wb_root;
        end else if (i_cmd.link) begin
            ram_addr  = r_root_b;
            ram_we    = r_root_a != r_root_b;
            ram_wdata = r_root_a;
        end
    end

    ufmc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (link)
    );

    // Item, decode and walker registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.decode) begin
            r_cell_a  <= cell_a;
            r_cell_b  <= cell_b;
            r_geom_ok <= geom_ok;
        end
        if (i_cmd.issue) begin
            r_src   <= src_sel;
            r_cur   <= src_sel;
            r_steps <= '0;
        end else if (i_cmd.find) begin
            if (found) begin
                if (i_cmd.sel_b) begin
                    r_root_b <= root;
                end else begin
                    r_root_a <= root;
                end
            end else begin
                r_cur   <= link;
                r_steps <= r_steps + 1'b1;
            end
        end
        if (i_cmd.res_clear) begin
            r_res_carved  <= 1'b0;
            r_res_invalid <= 1'b0;
        end else if (i_cmd.res_invalid) begin
            r_res_carved  <= 1'b0;
            r_res_invalid <= 1'b1;
        end else if (i_cmd.link) begin
            r_res_carved  <= r_root_a != r_root_b;
            r_res_invalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data.carved       <= r_res_carved;
            r_out_data.invalid_wall <= r_res_invalid;
        end
    end

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= clr_last ? '0 : r_clr + 1'b1;
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.is_clear = r_in.cmd == ufmc_pkg::CMD_CLEAR;
    assign o_stat.wall_ok  = r_geom_ok && (32'(r_cell_b) < MAX_CELLS);
    assign o_stat.found    = found;
    assign o_stat.clr_last = clr_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== design/ufmc_ctrl.sv =====
// Controller of the maze wall carver: sequences clearing, decode, the two
// root searches, write-backs, the link and result hand-off. Uses ufmc_pkg.

module ufmc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ufmc_pkg::t_dp_stat i_stat,
    output ufmc_pkg::t_dp_cmd  o_cmd
);

    ufmc_pkg::t_state r_state;
    ufmc_pkg::t_state n_state;
    logic             r_reply;
    logic             n_reply;

    // State register; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ufmc_pkg::S_CLEAR;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_reply    = r_reply;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ufmc_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    if (r_reply) begin
                        o_cmd.res_clear = 1'b1;
                        n_state         = ufmc_pkg::S_DONE;
                    end else begin
                        n_state = ufmc_pkg::S_IDLE;
                    end
                end
            end
            ufmc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ufmc_pkg::S_DECODE;
                end
            end
            ufmc_pkg::S_DECODE: begin
                if (i_stat.is_clear) begin
                    n_reply = 1'b1;
                    n_state = ufmc_pkg::S_CLEAR;
                end else begin
                    o_cmd.decode = 1'b1;
                    n_state      = ufmc_pkg::S_CHECK;
                end
            end
            ufmc_pkg::S_CHECK: begin
                if (i_stat.wall_ok) begin
                    o_cmd.issue = 1'b1;
                    n_state     = ufmc_pkg::S_FIND_A;
                end else begin
                    o_cmd.res_invalid = 1'b1;
                    n_state           = ufmc_pkg::S_DONE;
                end
            end
            ufmc_pkg::S_FIND_A: begin
                o_cmd.find = 1'b1;
                if (i_stat.found) begin
                    n_state = ufmc_pkg::S_WB_A;
                end
            end
            ufmc_pkg::S_WB_A: begin
                o_cmd.wb = 1'b1;
                n_state  = ufmc_pkg::S_ISSUE_B;
            end
            ufmc_pkg::S_ISSUE_B: begin
                o_cmd.issue = 1'b1;
                o_cmd.sel_b = 1'b1;
                n_state     = ufmc_pkg::S_FIND_B;
            end
            ufmc_pkg::S_FIND_B: begin
                o_cmd.find  = 1'b1;
                o_cmd.sel_b = 1'b1;
                if (i_stat.found) begin
                    n_state = ufmc_pkg::S_WB_B;
                end
            end
            ufmc_pkg::S_WB_B: begin
                o_cmd.wb    = 1'b1;
                o_cmd.sel_b = 1'b1;
                n_state     = ufmc_pkg::S_LINK;
            end
            ufmc_pkg::S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = ufmc_pkg::S_DONE;
            end
            ufmc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_reply        = 1'b0;
                    n_state        = ufmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ufmc_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/union_find_maze_wall_carver.sv =====
// Top level of the union-find maze wall carver: controller plus datapath.
// Uses ufmc_pkg, ufmc_chan_if, ufmc_ctrl and ufmc_dp.

// The block takes one item at a time. A wall item holds the input off from its
// accepted beat through decode, the range check, both root searches with their
// write-backs and the link until its result is loaded into the output register.
// All table traffic goes through the single read/write port of the parent
// table, one access per cycle, and that port sets the pace. A wall that lies
// outside the grid skips the searches and goes from the range check straight to
// the result load. Each clear command, and reset itself, runs a clearing pass
// over all MAX_CELLS+1 table entries, one entry per cycle, during which no item
// is taken; configuration writes are taken at any time. A finished result sits
// in an output register, so the block returns to idle as soon as it is loaded
// there.

module union_find_maze_wall_carver #(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_SIDE  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ufmc_chan_if.sink         i_cfg,
    ufmc_chan_if.sink         i_in,
    ufmc_chan_if.source       o_out
);

    ufmc_pkg::t_dp_cmd   dp_cmd;
    ufmc_pkg::t_dp_stat  dp_stat;
    logic                in_ready;
    logic                out_valid;
    ufmc_pkg::t_out_beat out_data;

    // Configuration is always accepted
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;

    ufmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ufmc_dp #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_SIDE  (MAX_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_in_data   (i_in.data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (out_data)
    );

endmodule

// ===== design/ufmc_checker.sv =====
// Port-level checks for the maze wall carver, bound to the top level.
// Depends on union_find_maze_wall_carver and its channel interfaces.

module ufmc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_carved,
    input logic i_invalid_wall
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_carved) && $stable(i_invalid_wall))
        else $error("result beat changed while stalled");

    // A wall is never both carved and rejected
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_carved && i_invalid_wall))
        else $error("carved and invalid_wall both set");

    // One item at a time: no input beat right after an accepted one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken in back-to-back cycles");

    // Reset starts the clearing pass, so input is held off
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // A new result appears only after work in progress held input off
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while block was idle");

endmodule

bind union_find_maze_wall_carver ufmc_checker u_ufmc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_carved       (o_out.data.carved),
    .i_invalid_wall (o_out.data.invalid_wall)
);
